// File: rtl/vlo_pkg.sv
package vlo_pkg;

   // Fixed field widths of the item and result payloads
   localparam int X_FIELD_BITS = 6;
   localparam int Y_FIELD_BITS = 6;
   localparam int Z_FIELD_BITS = 4;
   localparam int ADDR_FIELD_BITS = 16;
   localparam int LOG_ODDS_BITS = 16;

   // Stored log-odds of a voxel that has never been updated
   localparam logic signed [LOG_ODDS_BITS-1:0] UNKNOWN_LOG_ODDS = 16'sh8000;

   // Item kinds
   localparam logic KIND_OBSERVE = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   // Configuration register indexes (byte address 4*index)
   typedef enum logic [1:0] {
      REG_HIT_LOG_ODDS,
      REG_MISS_LOG_ODDS,
      REG_CLAMP_LOW,
      REG_CLAMP_HIGH
   } csr_reg_type;

   typedef struct packed {
      logic signed [LOG_ODDS_BITS-1:0] hit_log_odds;
      logic signed [LOG_ODDS_BITS-1:0] miss_log_odds;
      logic signed [LOG_ODDS_BITS-1:0] clamp_low;
      logic signed [LOG_ODDS_BITS-1:0] clamp_high;
   } cfg_type;

   typedef struct packed {
      logic kind;
      logic [X_FIELD_BITS-1:0] voxel_x;
      logic [Y_FIELD_BITS-1:0] voxel_y;
      logic [Z_FIELD_BITS-1:0] voxel_z;
      logic is_hit;
      logic [X_FIELD_BITS-1:0] box_min_x;
      logic [Y_FIELD_BITS-1:0] box_min_y;
      logic [Z_FIELD_BITS-1:0] box_min_z;
      logic [X_FIELD_BITS-1:0] box_max_x;
      logic [Y_FIELD_BITS-1:0] box_max_y;
      logic [Z_FIELD_BITS-1:0] box_max_z;
   } req_item_type;

   typedef struct packed {
      logic [ADDR_FIELD_BITS-1:0] voxel_address;
      logic first_touch;
      logic entry_valid;
      logic signed [LOG_ODDS_BITS-1:0] occupancy;
   } rsp_item_type;

   // Queue handshake between engine and queue
   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PREP,
      ST_QWAIT,
      ST_VADDR,
      ST_VREAD,
      ST_OBS_WR,
      ST_UPD_CALC,
      ST_UPD_WR,
      ST_EMPTY
   } engine_state_type;

endpackage

// File: rtl/vlo_ram.sv
module vlo_ram
   import vlo_pkg::*;
#(
   parameter int WIDTH = 48,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port, holds its data until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/vlo_queue.sv
module vlo_queue
   import vlo_pkg::*;
#(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_ctrl_type   ctrl,
   input  logic [WIDTH-1:0] push_data,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);

   localparam int AW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [FW-1:0] fill_ff, fill_in;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (ctrl.pop) begin
         head_in = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
      end
      if (ctrl.push) begin
         tail_in = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + AW'(1);
      end
      if (ctrl.push && !ctrl.pop) begin
         fill_in = fill_ff + FW'(1);
      end else if (ctrl.pop && !ctrl.push) begin
         fill_in = fill_ff - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   assign status.empty = (fill_ff == '0);
   assign status.full  = (fill_ff == FW'(DEPTH));

   // Queue storage: push at tail, pop reads head (data valid in the cycle after the pop)
   vlo_ram #(
      .WIDTH (WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ctrl.push),
      .waddr (tail_ff),
      .wdata (push_data),
      .re    (ctrl.pop),
      .raddr (head_ff),
      .rdata (pop_data)
   );

endmodule

// File: rtl/vlo_csr.sv
module vlo_csr
   import vlo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type     cfg_ff;
   csr_reg_type index;
   logic        wr;
   logic signed [LOG_ODDS_BITS-1:0] rd_value;

   assign csr_pready = 1'b1;
   assign index = csr_reg_type'(csr_paddr[3:2]);
   assign wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hit_log_odds  <= 16'sd158;
         cfg_ff.miss_log_odds <= -16'sd51;
         cfg_ff.clamp_low     <= -16'sd512;
         cfg_ff.clamp_high    <= 16'sd512;
      end else if (wr) begin
         unique case (index)
            REG_HIT_LOG_ODDS:  cfg_ff.hit_log_odds  <= csr_pwdata[15:0];
            REG_MISS_LOG_ODDS: cfg_ff.miss_log_odds <= csr_pwdata[15:0];
            REG_CLAMP_LOW:     cfg_ff.clamp_low     <= csr_pwdata[15:0];
            REG_CLAMP_HIGH:    cfg_ff.clamp_high    <= csr_pwdata[15:0];
            default:           cfg_ff.clamp_high    <= cfg_ff.clamp_high;
         endcase
      end
   end

   // Read back, sign-extended
   always_comb begin
      unique case (index)
         REG_HIT_LOG_ODDS:  rd_value = cfg_ff.hit_log_odds;
         REG_MISS_LOG_ODDS: rd_value = cfg_ff.miss_log_odds;
         REG_CLAMP_LOW:     rd_value = cfg_ff.clamp_low;
         REG_CLAMP_HIGH:    rd_value = cfg_ff.clamp_high;
         default:           rd_value = '0;
      endcase
   end

   assign csr_prdata = 32'(rd_value);
   assign cfg = cfg_ff;

endmodule

// File: rtl/vlo_engine.sv
module vlo_engine
   import vlo_pkg::*;
#(
   parameter int SIZE_X = 64,
   parameter int SIZE_Y = 64,
   parameter int SIZE_Z = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   localparam int VOXELS = SIZE_X * SIZE_Y * SIZE_Z;
   localparam int AW = $clog2(VOXELS);
   localparam int XW = $clog2(SIZE_X);
   localparam int YW = $clog2(SIZE_Y);
   localparam int ZW = $clog2(SIZE_Z);
   localparam int CW = XW + YW + ZW;
   localparam int CB = COUNT_BITS;
   localparam int VW = 2 * CB + LOG_ODDS_BITS;
   localparam logic [CB-1:0] COUNT_MAX = '1;

   function automatic logic [31:0] sat_coord(input logic [31:0] v, input logic [31:0] size);
      return (v >= size) ? size - 32'd1 : v;
   endfunction

   engine_state_type state_ff, state_in;

   req_item_type     item_ff;
   logic [CW-1:0]    coord_ff;
   logic [AW-1:0]    addr_ff;
   logic [AW-1:0]    clr_ff;
   logic signed [LOG_ODDS_BITS-1:0] inc_ff, base_ff;
   logic             add_ff;
   logic             rsp_valid_ff;
   rsp_item_type     rsp_item_ff;

   // Memory and queue hooks
   logic             v_we, v_re;
   logic [AW-1:0]    v_waddr;
   logic [VW-1:0]    v_wdata, v_rdata;
   queue_ctrl_type   q_ctrl;
   queue_status_type q_status;
   logic [CW-1:0]    q_rdata;

   logic             out_free;
   logic             load_rsp;
   rsp_item_type     rsp_next;

   // Voxel coordinates and linear address
   logic [XW-1:0] vx, sx, bminx, bmaxx;
   logic [YW-1:0] vy, sy, bminy, bmaxy;
   logic [ZW-1:0] vz, sz, bminz, bmaxz;
   logic [AW-1:0] addr_next;
   logic [31:0]   addr_wide;

   assign vx = coord_ff[XW-1:0];
   assign vy = coord_ff[XW +: YW];
   assign vz = coord_ff[XW + YW +: ZW];

   assign sx = XW'(sat_coord(32'(item_ff.voxel_x), SIZE_X));
   assign sy = YW'(sat_coord(32'(item_ff.voxel_y), SIZE_Y));
   assign sz = ZW'(sat_coord(32'(item_ff.voxel_z), SIZE_Z));
   assign bminx = XW'(sat_coord(32'(item_ff.box_min_x), SIZE_X));
   assign bminy = YW'(sat_coord(32'(item_ff.box_min_y), SIZE_Y));
   assign bminz = ZW'(sat_coord(32'(item_ff.box_min_z), SIZE_Z));
   assign bmaxx = XW'(sat_coord(32'(item_ff.box_max_x), SIZE_X));
   assign bmaxy = YW'(sat_coord(32'(item_ff.box_max_y), SIZE_Y));
   assign bmaxz = ZW'(sat_coord(32'(item_ff.box_max_z), SIZE_Z));

   assign addr_next = AW'(32'(vx) * 32'(SIZE_Y * SIZE_Z) + 32'(vy) * 32'(SIZE_Z) + 32'(vz));
   assign addr_wide = 32'(addr_ff);

   // Fields of the voxel word read back
   logic [CB-1:0] obs_rd, hit_rd, obs_new, hit_new;
   logic signed [LOG_ODDS_BITS-1:0] lo_rd;
   logic          first;

   assign obs_rd = v_rdata[CB-1:0];
   assign hit_rd = v_rdata[2*CB-1:CB];
   assign lo_rd  = v_rdata[2*CB +: LOG_ODDS_BITS];

   // Observe: saturating counter bumps
   assign obs_new = (obs_rd == COUNT_MAX) ? obs_rd : obs_rd + CB'(1);
   assign hit_new = (item_ff.is_hit && hit_rd != COUNT_MAX) ? hit_rd + CB'(1) : hit_rd;
   assign first   = (obs_new == CB'(1)) && !q_status.full;

   // Update, first half: pick increment, decide bound handling
   logic hit_dom, voxel_in_box;
   logic signed [LOG_ODDS_BITS-1:0] inc_sel, base_sel;
   logic add_sel;

   assign hit_dom = {hit_rd, 1'b0} >= {1'b0, obs_rd};
   assign inc_sel = hit_dom ? cfg.hit_log_odds : cfg.miss_log_odds;
   assign voxel_in_box = (vx >= bminx) && (vx <= bmaxx) && (vy >= bminy) && (vy <= bmaxy) &&
                         (vz >= bminz) && (vz <= bmaxz);

   always_comb begin
      priority if (!inc_sel[LOG_ODDS_BITS-1] && lo_rd >= cfg.clamp_high) begin
         base_sel = lo_rd;
         add_sel  = 1'b0;
      end else if ((inc_sel[LOG_ODDS_BITS-1] || inc_sel == '0) && lo_rd <= cfg.clamp_low) begin
         base_sel = cfg.clamp_low;
         add_sel  = 1'b0;
      end else begin
         base_sel = voxel_in_box ? lo_rd : cfg.clamp_low;
         add_sel  = 1'b1;
      end
   end

   // Update, second half: add and clamp, low bound first
   logic signed [LOG_ODDS_BITS:0] sum, lo_clamped, hi_clamped;
   logic signed [LOG_ODDS_BITS-1:0] occ_new;

   always_comb begin
      sum        = (LOG_ODDS_BITS + 1)'(base_ff) + (LOG_ODDS_BITS + 1)'(inc_ff);
      lo_clamped = (sum < (LOG_ODDS_BITS + 1)'(cfg.clamp_low)) ?
                   (LOG_ODDS_BITS + 1)'(cfg.clamp_low) : sum;
      hi_clamped = (lo_clamped > (LOG_ODDS_BITS + 1)'(cfg.clamp_high)) ?
                   (LOG_ODDS_BITS + 1)'(cfg.clamp_high) : lo_clamped;
      occ_new    = add_ff ? hi_clamped[LOG_ODDS_BITS-1:0] : base_ff;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequencer: next state, memory and queue strobes, result load
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      v_we      = 1'b0;
      v_re      = 1'b0;
      v_waddr   = addr_ff;
      v_wdata   = {UNKNOWN_LOG_ODDS, {(2*CB){1'b0}}};
      q_ctrl    = '0;
      load_rsp  = 1'b0;
      rsp_next  = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            v_we    = 1'b1;
            v_waddr = clr_ff;
            if (clr_ff == AW'(VOXELS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (item_ff.kind == KIND_OBSERVE) begin
               state_in = ST_VADDR;
            end else if (q_status.empty) begin
               state_in = ST_EMPTY;
            end else begin
               q_ctrl.pop = 1'b1;
               state_in   = ST_QWAIT;
            end
         end
         ST_QWAIT: state_in = ST_VADDR;
         ST_VADDR: state_in = ST_VREAD;
         ST_VREAD: begin
            v_re     = 1'b1;
            state_in = (item_ff.kind == KIND_OBSERVE) ? ST_OBS_WR : ST_UPD_CALC;
         end
         ST_OBS_WR: begin
            if (out_free) begin
               v_we        = 1'b1;
               v_wdata     = {lo_rd, hit_new, obs_new};
               q_ctrl.push = first;
               load_rsp    = 1'b1;
               rsp_next.voxel_address = addr_wide[ADDR_FIELD_BITS-1:0];
               rsp_next.first_touch   = first;
               state_in    = ST_IDLE;
            end
         end
         ST_UPD_CALC: state_in = ST_UPD_WR;
         ST_UPD_WR: begin
            if (out_free) begin
               v_we     = 1'b1;
               v_wdata  = {occ_new, {(2*CB){1'b0}}};
               load_rsp = 1'b1;
               rsp_next.voxel_address = addr_wide[ADDR_FIELD_BITS-1:0];
               rsp_next.entry_valid   = 1'b1;
               rsp_next.occupancy     = occ_new;
               state_in = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Clearing sweep address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (state_ff == ST_CLEAR) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         item_ff <= req_item;
      end
      if (state_ff == ST_PREP) begin
         coord_ff <= {sz, sy, sx};
      end else if (state_ff == ST_QWAIT) begin
         coord_ff <= q_rdata;
      end
      if (state_ff == ST_VADDR) begin
         addr_ff <= addr_next;
      end
      if (state_ff == ST_UPD_CALC) begin
         inc_ff  <= inc_sel;
         base_ff <= base_sel;
         add_ff  <= add_sel;
      end
   end

   // Output register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_item_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   vlo_ram #(
      .WIDTH (VW),
      .DEPTH (VOXELS)
   ) u_voxel_ram (
      .clock (clock),
      .we    (v_we),
      .waddr (v_waddr),
      .wdata (v_wdata),
      .re    (v_re),
      .raddr (addr_ff),
      .rdata (v_rdata)
   );

   vlo_queue #(
      .WIDTH (CW),
      .DEPTH (VOXELS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (q_ctrl),
      .push_data (coord_ff),
      .pop_data  (q_rdata),
      .status    (q_status)
   );

`ifndef NO_ASSERTIONS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("item accepted during clearing pass");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_ctrl.push |-> !q_status.full)
      else $error("queue push while full");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_ctrl.pop |-> (!q_status.empty && !q_ctrl.push))
      else $error("queue pop while empty or with push");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      v_we |-> (state_ff == ST_CLEAR || state_ff == ST_OBS_WR || state_ff == ST_UPD_WR))
      else $error("voxel store written outside a write step");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OBS_WR || $past(state_ff) == ST_UPD_WR ||
                               $past(state_ff) == ST_EMPTY))
      else $error("result raised without a finished item");
`endif

endmodule

// File: rtl/voxel_log_odds_occupancy_update_top.sv
// Voxel log-odds occupancy map. Each voxel holds saturating hit and observation counters and a
// signed Q8.8 log-odds value in one synchronous store; touched voxels go into a FIFO of
// coordinates. An observe item (req_tuser = 0) bumps the counters and queues the voxel on its
// first touch; an update item (req_tuser = 1) pops one voxel, applies the hit or miss
// increment with the box and clamp rules, clears its counters and returns the new value.
// Items are handled one at a time by a sequencer around the voxel store; the last step of an
// item waits while the output register holds a result not yet taken on rsp_tready. A result
// waiting in the output register does not block acceptance of the next item. After reset a
// clearing pass writes every voxel entry, one per cycle, SIZE_X*SIZE_Y*SIZE_Z entries in all
// (65536 at the default sizes); req_tready stays low until it ends, while register writes
// are taken as usual.
module voxel_log_odds_occupancy_update_top
   import vlo_pkg::*;
#(
   parameter int SIZE_X = 64,
   parameter int SIZE_Y = 64,
   parameter int SIZE_Z = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Input items
   input  logic        req_tvalid,
   output logic        req_tready,
   // voxel_x[5:0] voxel_y[11:6] voxel_z[15:12] is_hit[16] box_min_x[22:17]
   // box_min_y[28:23] box_min_z[32:29] box_max_x[38:33] box_max_y[44:39] box_max_z[48:45]
   input  logic [55:0] req_tdata,
   // kind[0]
   input  logic        req_tuser,
   // Result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // voxel_address[15:0] occupancy[31:16]
   output logic [31:0] rsp_tdata,
   // first_touch[0] entry_valid[1]
   output logic [1:0]  rsp_tuser,
   // Configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type      cfg;
   req_item_type req_item;
   rsp_item_type rsp_item;

   // Unpack the input item
   assign req_item.kind      = req_tuser;
   assign req_item.voxel_x   = req_tdata[5:0];
   assign req_item.voxel_y   = req_tdata[11:6];
   assign req_item.voxel_z   = req_tdata[15:12];
   assign req_item.is_hit    = req_tdata[16];
   assign req_item.box_min_x = req_tdata[22:17];
   assign req_item.box_min_y = req_tdata[28:23];
   assign req_item.box_min_z = req_tdata[32:29];
   assign req_item.box_max_x = req_tdata[38:33];
   assign req_item.box_max_y = req_tdata[44:39];
   assign req_item.box_max_z = req_tdata[48:45];

   // Pack the result item
   assign rsp_tdata = {rsp_item.occupancy, rsp_item.voxel_address};
   assign rsp_tuser = {rsp_item.entry_valid, rsp_item.first_touch};

   vlo_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   vlo_engine #(
      .SIZE_X     (SIZE_X),
      .SIZE_Y     (SIZE_Y),
      .SIZE_Z     (SIZE_Z),
      .COUNT_BITS (COUNT_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_item  (req_item),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

import vlo_pkg::*;

// Tracks the voxel map as the block should see it and checks every result item in order
class log_odds_tracker;
   bit [15:0] obs_count [65536];
   bit [15:0] hit_count [65536];
   bit signed [15:0] log_odds [65536];
   bit [15:0] touched [$];
   rsp_item_type expected [$];
   int hit_inc;
   int miss_inc;
   int clamp_lo;
   int clamp_hi;
   int errors;

   function new();
      foreach (log_odds[i]) log_odds[i] = UNKNOWN_LOG_ODDS;
      hit_inc = 158;
      miss_inc = -51;
      clamp_lo = -512;
      clamp_hi = 512;
      errors = 0;
   endfunction

   function void set_reg(csr_reg_type r, logic [15:0] v);
      case (r)
         REG_HIT_LOG_ODDS:  hit_inc = int'($signed(v));
         REG_MISS_LOG_ODDS: miss_inc = int'($signed(v));
         REG_CLAMP_LOW:     clamp_lo = int'($signed(v));
         default:           clamp_hi = int'($signed(v));
      endcase
   endfunction

   // Work out the result of one accepted item and advance the map
   function void predict_result(req_item_type it);
      rsp_item_type r;
      bit [15:0] a;
      int inc;
      int cur;
      int total;
      bit in_box;
      r = '0;
      if (it.kind == KIND_OBSERVE) begin
         a = {it.voxel_x, it.voxel_y, it.voxel_z};
         // saturate both counters, queue on the first touch
         if (obs_count[a] != 16'hFFFF) obs_count[a] = obs_count[a] + 16'd1;
         if (obs_count[a] == 16'd1) begin
            touched.push_back(a);
            r.first_touch = 1'b1;
         end
         if (it.is_hit && hit_count[a] != 16'hFFFF) hit_count[a] = hit_count[a] + 16'd1;
         r.voxel_address = a;
      end else if (touched.size() != 0) begin
         a = touched.pop_front();
         if (int'(hit_count[a]) >= int'(obs_count[a]) - int'(hit_count[a])) inc = hit_inc;
         else inc = miss_inc;
         hit_count[a] = '0;
         obs_count[a] = '0;
         cur = log_odds[a];
         // hold the store at the upper bound, pin it at the lower bound
         if (!(inc >= 0 && cur >= clamp_hi)) begin
            if (inc <= 0 && cur <= clamp_lo) begin
               log_odds[a] = clamp_lo[15:0];
            end else begin
               in_box = a[15:10] >= it.box_min_x && a[15:10] <= it.box_max_x &&
                        a[9:4] >= it.box_min_y && a[9:4] <= it.box_max_y &&
                        a[3:0] >= it.box_min_z && a[3:0] <= it.box_max_z;
               if (!in_box) cur = clamp_lo;
               total = cur + inc;
               if (total < clamp_lo) total = clamp_lo;
               if (total > clamp_hi) total = clamp_hi;
               log_odds[a] = total[15:0];
            end
         end
         r.voxel_address = a;
         r.entry_valid = 1'b1;
         r.occupancy = log_odds[a];
      end
      expected.push_back(r);
   endfunction

   function void check_result(rsp_item_type got);
      rsp_item_type w;
      if (expected.size() == 0) begin
         $error("result item with none outstanding: voxel_address %0d", got.voxel_address);
         errors++;
         return;
      end
      w = expected.pop_front();
      if (got.voxel_address !== w.voxel_address) begin
         $error("voxel_address: expected %0d, got %0d", w.voxel_address, got.voxel_address);
         errors++;
      end
      if (got.first_touch !== w.first_touch) begin
         $error("first_touch: expected %0d, got %0d", w.first_touch, got.first_touch);
         errors++;
      end
      if (got.entry_valid !== w.entry_valid) begin
         $error("entry_valid: expected %0d, got %0d", w.entry_valid, got.entry_valid);
         errors++;
      end
      if (got.occupancy !== w.occupancy) begin
         $error("occupancy: expected %0d, got %0d", w.occupancy, got.occupancy);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import vlo_pkg::*;

   localparam int REQ_BITS = $bits(req_item_type);
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int REPEAT_OBSERVES = 24;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 200;
   localparam int POOL_SIZE = 6;
   localparam logic [15:0] BOX_ALL_LO = 16'h0000;
   localparam logic [15:0] BOX_ALL_HI = 16'hFFFF;
   // x range reversed, so no voxel lies inside
   localparam logic [15:0] BOX_INVERTED_LO = 16'hFC00;
   localparam logic [15:0] BOX_INVERTED_HI = 16'h03FF;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [55:0] req_tdata;
   logic req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [31:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [3:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   log_odds_tracker tracker = new();
   int burst_left = 0;
   int gap_limit = 12;
   int holds_asked = 0;

   // hit, miss, clamp low, clamp high; the first row is the reset setting, the last is random
   int phase_cfg [RANDOM_PHASES][4] = '{
      '{158, -51, -512, 512},
      '{32767, -32768, -32768, 32767},
      '{0, 0, -100, 100},
      '{-300, 400, 200, -200},
      '{1000, -1000, 300, 300},
      '{32767, 32767, 32767, -32768},
      '{-32768, -1, -32768, 0},
      '{0, 0, 0, 0}
   };

   voxel_log_odds_occupancy_update_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Offer one item in bursts with random gaps, note it once taken
   task automatic send_item(input req_item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, gap_limit);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= it.kind;
      req_tdata <= {7'd0, it.box_max_z, it.box_max_y, it.box_max_x, it.box_min_z, it.box_min_y,
                    it.box_min_x, it.is_hit, it.voxel_z, it.voxel_y, it.voxel_x};
      do @(posedge clock); while (!req_tready);
      tracker.predict_result(it);
      burst_left--;
   endtask

   // Fields that the item kind ignores stay random
   task automatic send_observe(input logic [15:0] addr, input logic hit);
      req_item_type it;
      it = req_item_type'(REQ_BITS'({$urandom, $urandom}));
      it.kind = KIND_OBSERVE;
      {it.voxel_x, it.voxel_y, it.voxel_z} = addr;
      it.is_hit = hit;
      send_item(it);
   endtask

   task automatic send_update(input logic [15:0] lo, input logic [15:0] hi);
      req_item_type it;
      it = req_item_type'(REQ_BITS'({$urandom, $urandom}));
      it.kind = KIND_UPDATE;
      {it.box_min_x, it.box_min_y, it.box_min_z} = lo;
      {it.box_max_x, it.box_max_y, it.box_max_z} = hi;
      send_item(it);
   endtask

   task automatic release_req();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
   endtask

   task automatic wait_drained();
      while (tracker.expected.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type r, input logic [15:0] v);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {r, 2'b00};
      csr_pwdata <= {{16{v[15]}}, v};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_reg(r, v);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Random voxel with each axis often pushed to an edge of the map
   function automatic logic [15:0] pick_voxel();
      logic [15:0] a;
      a = 16'($urandom);
      if ($urandom_range(0, 3) == 0) a[15:10] = $urandom_range(0, 1) ? 6'd63 : 6'd0;
      if ($urandom_range(0, 3) == 0) a[9:4] = $urandom_range(0, 1) ? 6'd63 : 6'd0;
      if ($urandom_range(0, 3) == 0) a[3:0] = $urandom_range(0, 1) ? 4'd15 : 4'd0;
      return a;
   endfunction

   // Check every result item taken
   always @(posedge clock) begin
      rsp_item_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[15:0], rsp_tuser[0], rsp_tuser[1], rsp_tdata[31:16]};
         tracker.check_result(got);
      end
   end

   // Result side: stall on stretches of changing density, plus long hold-offs on request
   initial begin
      int mode;
      int span;
      int holds_given;
      holds_given = 0;
      rsp_tready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 120);
         repeat (span) begin
            @(negedge clock);
            if (holds_asked != holds_given) begin
               rsp_tready <= 1'b0;
               repeat (LONG_HOLD_CYCLES) @(negedge clock);
               holds_given++;
               rsp_tready <= 1'b1;
            end else begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= 1'($urandom_range(0, 1));
                  2: rsp_tready <= ($urandom_range(0, 3) == 0);
                  default: rsp_tready <= ($urandom_range(0, 7) != 0);
               endcase
            end
         end
      end
   end

   initial begin
      #100000000;
      $display("tb_top: errors");
      $finish;
   end

   initial begin
      int p;
      int i;
      int n;
      int sent;
      int hit_bias;
      int pool_used;
      logic [15:0] pool [POOL_SIZE];
      logic [15:0] a;
      logic [15:0] lo;
      logic [15:0] hi;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset setting
      send_update(BOX_ALL_LO, BOX_ALL_HI);
      send_observe(16'h0000, 1'b1);
      send_observe(16'h0000, 1'b0);
      send_observe(16'hFFFF, 1'b0);
      send_observe(16'hFFFF, 1'b0);
      send_observe({6'd5, 6'd40, 4'd9}, 1'b1);
      send_observe({6'd63, 6'd0, 4'd15}, 1'b1);
      send_update(BOX_ALL_LO, BOX_ALL_HI);
      send_update(BOX_ALL_LO, {6'd62, 6'd63, 4'd15});
      send_update(BOX_INVERTED_LO, BOX_INVERTED_HI);
      send_update({6'd63, 6'd0, 4'd15}, {6'd63, 6'd0, 4'd15});
      send_update(BOX_ALL_LO, BOX_ALL_HI);
      send_observe(16'h0000, 1'b1);
      send_update(BOX_ALL_LO, BOX_ALL_HI);
      send_observe(16'hFFFF, 1'b0);
      send_update(16'hFFFF, 16'hFFFF);
      send_observe({6'd5, 6'd40, 4'd9}, 1'b1);
      send_observe({6'd5, 6'd40, 4'd9}, 1'b0);
      send_observe({6'd5, 6'd40, 4'd9}, 1'b0);
      send_update(BOX_ALL_LO, BOX_ALL_HI);

      // Random phases, each under its own register setting
      for (p = 0; p < RANDOM_PHASES; p++) begin
         if (p > 0) begin
            release_req();
            wait_drained();
            for (i = 0; i < 4; i++) begin
               if (p == RANDOM_PHASES - 1) write_reg(csr_reg_type'(i), 16'($urandom));
               else write_reg(csr_reg_type'(i), 16'(phase_cfg[p][i]));
            end
         end
         for (i = 0; i < POOL_SIZE; i++) pool[i] = pick_voxel();
         pool_used = $urandom_range(1, POOL_SIZE);
         if (p == 2) holds_asked++;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
               send_item(req_item_type'(REQ_BITS'({$urandom, $urandom})));
               sent++;
            end else begin
               // observe a few voxels, mostly from the pool, then pop some of them
               hit_bias = $urandom_range(0, 4);
               n = $urandom_range(1, 10);
               repeat (n) begin
                  if ($urandom_range(0, 7) == 0) a = pick_voxel();
                  else a = pool[$urandom_range(0, pool_used - 1)];
                  send_observe(a, $urandom_range(1, 4) <= hit_bias);
                  sent++;
               end
               n = $urandom_range(1, tracker.touched.size() + 1);
               repeat (n) begin
                  case ($urandom_range(0, 9))
                     0, 1: begin
                        lo = 16'($urandom);
                        hi = 16'($urandom);
                     end
                     2, 3: begin
                        // tight box on the voxel about to be popped, or one step beside it
                        if (tracker.touched.size() != 0) a = tracker.touched[0];
                        else a = pick_voxel();
                        if ($urandom_range(0, 1)) a = a ^ 16'h0010;
                        lo = a;
                        hi = a;
                     end
                     4: begin
                        lo = BOX_INVERTED_LO;
                        hi = BOX_INVERTED_HI;
                     end
                     default: begin
                        lo = BOX_ALL_LO;
                        hi = BOX_ALL_HI;
                     end
                  endcase
                  send_update(lo, hi);
                  sent++;
               end
            end
         end
      end

      // Widest clamps: empty the queue, then hit one voxel many times back to back
      release_req();
      wait_drained();
      write_reg(REG_HIT_LOG_ODDS, 16'd256);
      write_reg(REG_MISS_LOG_ODDS, -16'sd256);
      write_reg(REG_CLAMP_LOW, 16'h8000);
      write_reg(REG_CLAMP_HIGH, 16'h7FFF);
      while (tracker.touched.size() != 0) send_update(BOX_ALL_LO, BOX_ALL_HI);
      gap_limit = 2;
      a = pick_voxel();
      repeat (REPEAT_OBSERVES) send_observe(a, 1'b1);
      send_update(BOX_ALL_LO, BOX_ALL_HI);

      release_req();
      wait_drained();
      repeat (20) @(posedge clock);
      if (tracker.errors == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

endmodule
